// ----- rtl/core/hdrf_pkg.sv -----
// Shared types, constants, microcode table and helper functions of the hex dump row formatter.
package hdrf_pkg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_in_beat;

    typedef struct packed {
        logic [6:0] text_char;
        logic       row_end;
        logic       last_of_run;
    } t_out_beat;

    localparam logic CMD_DATA   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_BAR   = 7'h7C;
    localparam logic [6:0] CH_DOT   = 7'h2E;
    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd126;

    // Offset is printed as eight nibbles, most significant first.
    localparam int unsigned OFS_NIBBLES = 8;

    typedef logic [3:0] t_step;

    localparam t_step ST_IDLE   = 4'd0;
    localparam t_step ST_OFS    = 4'd1;
    localparam t_step ST_OSP0   = 4'd2;
    localparam t_step ST_OSP1   = 4'd3;
    localparam t_step ST_HI     = 4'd4;
    localparam t_step ST_LO     = 4'd5;
    localparam t_step ST_BSP    = 4'd6;
    localparam t_step ST_PAD0   = 4'd7;
    localparam t_step ST_PAD1   = 4'd8;
    localparam t_step ST_PAD2   = 4'd9;
    localparam t_step ST_CL_SP  = 4'd10;
    localparam t_step ST_CL_BAR = 4'd11;
    localparam t_step ST_ASC    = 4'd12;
    localparam t_step ST_CL_END = 4'd13;

    typedef enum logic [2:0] {
        SRC_SPACE   = 3'd0,
        SRC_BAR     = 3'd1,
        SRC_OFS_NIB = 3'd2,
        SRC_HI_NIB  = 3'd3,
        SRC_LO_NIB  = 3'd4,
        SRC_ASCII   = 3'd5
    } t_src;

    typedef enum logic [2:0] {
        JC_NEXT     = 3'd0,
        JC_ALWAYS   = 3'd1,
        JC_LOOP_DN  = 3'd2,
        JC_LOOP_UP  = 3'd3,
        JC_FULL     = 3'd4,
        JC_DISPATCH = 3'd5
    } t_jc;

    typedef struct packed {
        t_src  src;
        logic  emit;
        logic  row_end;
        logic  cnt_clr;
        logic  row_done;
        t_jc   jc;
        t_step target;
    } t_uword;

    // Status from datapath to sequencer.
    typedef struct packed {
        logic is_finish;
        logic pos_zero;
        logic cnt_zero;
        logic cnt_last;
        logic row_full;
        logic out_free;
    } t_flags;

    // Control from sequencer to datapath.
    typedef struct packed {
        t_uword uw;
        logic   advance;
        logic   accept;
        logic   last;
    } t_ctl;

    function automatic t_uword uw_make(t_src src, logic emit, logic row_end, logic cnt_clr,
                                       logic row_done, t_jc jc, t_step target);
        t_uword w;
        w.src      = src;
        w.emit     = emit;
        w.row_end  = row_end;
        w.cnt_clr  = cnt_clr;
        w.row_done = row_done;
        w.jc       = jc;
        w.target   = target;
        return w;
    endfunction

    // Control store: one word per step.
    function automatic t_uword ucode(t_step s);
        t_uword w;
        case (s)
            ST_IDLE:   w = uw_make(SRC_SPACE,   1'b0, 1'b0, 1'b0, 1'b0, JC_DISPATCH, ST_IDLE);
            ST_OFS:    w = uw_make(SRC_OFS_NIB, 1'b1, 1'b0, 1'b0, 1'b0, JC_LOOP_DN,  ST_OFS);
            ST_OSP0:   w = uw_make(SRC_SPACE,   1'b1, 1'b0, 1'b0, 1'b0, JC_NEXT,     ST_IDLE);
            ST_OSP1:   w = uw_make(SRC_SPACE,   1'b1, 1'b0, 1'b0, 1'b0, JC_NEXT,     ST_IDLE);
            ST_HI:     w = uw_make(SRC_HI_NIB,  1'b1, 1'b0, 1'b0, 1'b0, JC_NEXT,     ST_IDLE);
            ST_LO:     w = uw_make(SRC_LO_NIB,  1'b1, 1'b0, 1'b0, 1'b0, JC_NEXT,     ST_IDLE);
            ST_BSP:    w = uw_make(SRC_SPACE,   1'b1, 1'b0, 1'b0, 1'b0, JC_FULL,     ST_CL_SP);
            ST_PAD0:   w = uw_make(SRC_SPACE,   1'b1, 1'b0, 1'b0, 1'b0, JC_NEXT,     ST_IDLE);
            ST_PAD1:   w = uw_make(SRC_SPACE,   1'b1, 1'b0, 1'b0, 1'b0, JC_NEXT,     ST_IDLE);
            ST_PAD2:   w = uw_make(SRC_SPACE,   1'b1, 1'b0, 1'b0, 1'b0, JC_LOOP_DN,  ST_PAD0);
            ST_CL_SP:  w = uw_make(SRC_SPACE,   1'b1, 1'b0, 1'b0, 1'b0, JC_NEXT,     ST_IDLE);
            ST_CL_BAR: w = uw_make(SRC_BAR,     1'b1, 1'b0, 1'b1, 1'b0, JC_NEXT,     ST_IDLE);
            ST_ASC:    w = uw_make(SRC_ASCII,   1'b1, 1'b0, 1'b0, 1'b0, JC_LOOP_UP,  ST_ASC);
            ST_CL_END: w = uw_make(SRC_BAR,     1'b1, 1'b1, 1'b0, 1'b1, JC_ALWAYS,   ST_IDLE);
            default:   w = uw_make(SRC_SPACE,   1'b0, 1'b0, 1'b0, 1'b0, JC_ALWAYS,   ST_IDLE);
        endcase
        return w;
    endfunction

    function automatic logic [6:0] nib_char(logic [3:0] v);
        return (v < 4'd10) ? (7'h30 + {3'b000, v}) : (7'h37 + {3'b000, v});
    endfunction

    function automatic logic [6:0] shown(logic [7:0] b);
        return (b >= PRINT_LO && b <= PRINT_HI) ? b[6:0] : CH_DOT;
    endfunction

endpackage

// ----- rtl/core/hdrf_seq.sv -----
// Microcode sequencer: step counter, control store lookup and jump logic.
module hdrf_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  hdrf_pkg::t_flags i_flags,
    output hdrf_pkg::t_ctl   o_ctl,
    output logic            o_in_stall
);

    hdrf_pkg::t_step  r_step;
    hdrf_pkg::t_step  n_step;
    hdrf_pkg::t_step  w_jump;
    hdrf_pkg::t_uword w_uw;
    logic             w_idle;
    logic             w_accept;
    logic             w_advance;

    assign w_uw      = hdrf_pkg::ucode(r_step);
    assign w_idle    = (r_step == hdrf_pkg::ST_IDLE);
    assign w_accept  = w_idle && i_in_valid;
    // Hold the step while an emitted character cannot be taken.
    assign w_advance = !w_uw.emit || i_flags.out_free;

    always_comb begin
        case (w_uw.jc)
            hdrf_pkg::JC_NEXT:    w_jump = r_step + 4'd1;
            hdrf_pkg::JC_ALWAYS:  w_jump = w_uw.target;
            hdrf_pkg::JC_LOOP_DN: w_jump = i_flags.cnt_zero ? r_step + 4'd1 : w_uw.target;
            hdrf_pkg::JC_LOOP_UP: w_jump = i_flags.cnt_last ? r_step + 4'd1 : w_uw.target;
            hdrf_pkg::JC_FULL:    w_jump = i_flags.row_full ? w_uw.target : hdrf_pkg::ST_IDLE;
            hdrf_pkg::JC_DISPATCH: begin
                if (!w_accept) begin
                    w_jump = hdrf_pkg::ST_IDLE;
                end else if (i_flags.is_finish) begin
                    w_jump = i_flags.pos_zero ? hdrf_pkg::ST_IDLE : hdrf_pkg::ST_PAD0;
                end else begin
                    w_jump = i_flags.pos_zero ? hdrf_pkg::ST_OFS : hdrf_pkg::ST_HI;
                end
            end
            default:              w_jump = hdrf_pkg::ST_IDLE;
        endcase
    end

    assign n_step = w_advance ? w_jump : r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= hdrf_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctl.uw      = w_uw;
    assign o_ctl.advance = w_advance;
    assign o_ctl.accept  = w_accept;
    // The character that sends the sequencer back to idle closes the run.
    assign o_ctl.last    = (w_jump == hdrf_pkg::ST_IDLE);
    assign o_in_stall    = !w_idle;

endmodule

// ----- rtl/core/hdrf_dp.sv -----
// Datapath: row buffer, offset and position registers, loop counter, character mux, output register.
module hdrf_dp #(
    parameter int unsigned ROW_BYTES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hdrf_pkg::t_in_beat  i_in_data,
    input  logic                i_cfg_valid,
    input  logic [31:0]         i_cfg_data,
    input  hdrf_pkg::t_ctl      i_ctl,
    input  logic                i_out_stall,
    output hdrf_pkg::t_flags    o_flags,
    output logic                o_out_valid,
    output hdrf_pkg::t_out_beat o_out_data
);

    localparam int unsigned CW = $clog2(ROW_BYTES);
    localparam int unsigned PW = $clog2(ROW_BYTES + 1);

    logic [7:0]    r_row_buf [ROW_BYTES];
    logic [7:0]    r_buf_rd;
    logic [7:0]    r_byte;
    logic [PW-1:0] r_pos;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic [31:0]   r_offset;
    logic [31:0]   r_base;
    logic          r_fresh;
    logic          r_fin;
    logic          r_out_valid;
    hdrf_pkg::t_out_beat r_out;

    logic          w_out_free;
    logic          w_step;
    logic          w_acc_data;
    logic          w_acc_fin;
    logic [6:0]    w_char;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step     = i_ctl.advance;
    assign w_acc_data = i_ctl.accept && (i_in_data.cmd == hdrf_pkg::CMD_DATA);
    assign w_acc_fin  = i_ctl.accept && (i_in_data.cmd == hdrf_pkg::CMD_FINISH);

    always_comb begin
        case (i_ctl.uw.src)
            hdrf_pkg::SRC_SPACE:   w_char = hdrf_pkg::CH_SPACE;
            hdrf_pkg::SRC_BAR:     w_char = hdrf_pkg::CH_BAR;
            hdrf_pkg::SRC_OFS_NIB: w_char = hdrf_pkg::nib_char(r_offset[{r_cnt[2:0], 2'b00} +: 4]);
            hdrf_pkg::SRC_HI_NIB:  w_char = hdrf_pkg::nib_char(r_byte[7:4]);
            hdrf_pkg::SRC_LO_NIB:  w_char = hdrf_pkg::nib_char(r_byte[3:0]);
            hdrf_pkg::SRC_ASCII: begin
                // Slots past the held bytes of a partial row show blank.
                w_char = ({{(PW-CW){1'b0}}, r_cnt} < r_pos) ? hdrf_pkg::shown(r_buf_rd)
                                                            : hdrf_pkg::CH_SPACE;
            end
            default:               w_char = hdrf_pkg::CH_SPACE;
        endcase
    end

    // Loop counter: offset nibbles, pad slots and the ASCII column.
    always_comb begin
        n_cnt = r_cnt;
        if (w_acc_data) begin
            if (r_pos == '0) begin
                n_cnt = CW'(hdrf_pkg::OFS_NIBBLES - 1);
            end
        end else if (w_acc_fin) begin
            if (r_pos != '0) begin
                n_cnt = CW'(ROW_BYTES - 1) - r_pos[CW-1:0];
            end
        end else if (w_step) begin
            case (i_ctl.uw.jc)
                hdrf_pkg::JC_LOOP_DN: begin
                    if (r_cnt != '0) begin
                        n_cnt = r_cnt - CW'(1);
                    end
                end
                hdrf_pkg::JC_LOOP_UP: begin
                    if (r_cnt != CW'(ROW_BYTES - 1)) begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
                default: begin
                    if (i_ctl.uw.cnt_clr) begin
                        n_cnt = '0;
                    end
                end
            endcase
        end
    end

    // Read ahead at the next count so the data lines up with r_cnt.
    always_ff @(posedge i_clk) begin
        if (w_acc_data) begin
            r_row_buf[r_pos[CW-1:0]] <= i_in_data.data_byte;
            r_byte                   <= i_in_data.data_byte;
        end
        r_buf_rd <= r_row_buf[n_cnt];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 32'd0;
        end else if (i_cfg_valid) begin
            r_base <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_offset <= 32'd0;
            r_fresh  <= 1'b1;
            r_fin    <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_acc_data) begin
                r_pos <= r_pos + PW'(1);
                r_fin <= 1'b0;
                if (r_fresh) begin
                    r_offset <= r_base;
                    r_fresh  <= 1'b0;
                end
            end else if (w_acc_fin) begin
                r_fin   <= 1'b1;
                r_fresh <= 1'b1;
                if (r_pos == '0) begin
                    r_offset <= r_base;
                end
            end else if (w_step) begin
                if (i_ctl.uw.row_done) begin
                    r_pos <= '0;
                    if (r_fin) begin
                        r_offset <= r_base;
                    end else begin
                        r_offset <= r_offset + 32'(ROW_BYTES);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.uw.emit && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.uw.emit && w_out_free) begin
            r_out.text_char   <= w_char;
            r_out.row_end     <= i_ctl.uw.row_end;
            r_out.last_of_run <= i_ctl.last;
        end
    end

    assign o_flags.is_finish = (i_in_data.cmd == hdrf_pkg::CMD_FINISH);
    assign o_flags.pos_zero  = (r_pos == '0);
    assign o_flags.cnt_zero  = (r_cnt == '0);
    assign o_flags.cnt_last  = (r_cnt == CW'(ROW_BYTES - 1));
    assign o_flags.row_full  = (r_pos == PW'(ROW_BYTES));
    assign o_flags.out_free  = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/core/hex_dump_row_formatter_top.sv -----
// Top level of the hex dump row formatter: sequencer, datapath and checks.
//
//  channel  direction  handshake          payload
//  in       input      i_in_valid/stall   t_in_beat  {cmd, data_byte}
//  out      output     o_out_valid/stall  t_out_beat {text_char, row_end, last_of_run}
//  cfg      input      i_cfg_valid/ready  base_offset, 32 bits
//
// One character leaves per cycle while the sequencer runs; each item is dispatched from
// idle. A data byte gives two hex digits and a space, after eight offset nibbles and
// two spaces at a row start; a row-filling byte adds a space, a bar, ROW_BYTES ASCII
// characters and a bar. An empty-row finish gives nothing, else three spaces per
// missing byte and the row close. Reset clears the step counter, row position, offset
// and output valid. An output stall freezes the sequencer on its emitting step.
module hex_dump_row_formatter_top #(
    parameter int unsigned ROW_BYTES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hdrf_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hdrf_pkg::t_out_beat o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [31:0]         i_cfg_data
);

    hdrf_pkg::t_flags w_flags;
    hdrf_pkg::t_ctl   w_ctl;

    assign o_cfg_ready = 1'b1;

    hdrf_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_flags    (w_flags),
        .o_ctl      (w_ctl),
        .o_in_stall (o_in_stall)
    );

    hdrf_dp #(
        .ROW_BYTES (ROW_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_ctl       (w_ctl),
        .i_out_stall (i_out_stall),
        .o_flags     (w_flags),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // A data beat always produces characters, so the sequencer leaves idle.
    a_data_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.cmd == hdrf_pkg::CMD_DATA) |=> o_in_stall)
        else $error("data beat accepted without starting a run");

    // The row close is the bar character and always ends the run.
    a_row_end_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.row_end) |->
        (o_out_data.text_char == hdrf_pkg::CH_BAR && o_out_data.last_of_run))
        else $error("row end not on a closing bar at run end");

    // No new beat is taken before the run's last character was registered.
    a_last_before_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_in_stall)) |-> (o_out_valid && o_out_data.last_of_run))
        else $error("sequencer went idle without a last character");

endmodule

// ----- bench/hdrf_dump_checker.sv -----
`timescale 1ns / 1ps
// Checker for the hex dump row formatter: predicts every text character and compares it.
module hdrf_dump_checker #(
    parameter int unsigned ROW_LEN = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  hdrf_pkg::t_in_beat  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  hdrf_pkg::t_out_beat i_out_data,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [31:0]         i_cfg_data,
    output int                  o_mismatches,
    output int                  o_outstanding
);

    logic [7:0]          row_buf [0:15];
    int unsigned         row_fill;
    logic [31:0]         row_addr;
    logic [31:0]         base_addr;
    bit                  dump_fresh;
    hdrf_pkg::t_out_beat text_q [$];
    hdrf_pkg::t_out_beat line_chars [0:79];
    int                  line_len;
    int                  mismatch_cnt = 0;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    function automatic logic [6:0] nibble_glyph(logic [3:0] v);
        if (v > 4'd9)
            return 7'h41 + {3'b000, v} - 7'd10;
        return 7'h30 + {3'b000, v};
    endfunction

    function automatic logic [6:0] ascii_cell(logic [7:0] b);
        if (b < 8'd32 || b > 8'd126)
            return hdrf_pkg::CH_DOT;
        return b[6:0];
    endfunction

    task automatic emit_char(input logic [6:0] c, input logic ends_row);
        line_chars[line_len] = {c, ends_row, 1'b0};
        line_len++;
    endtask

    task automatic close_row(input int unsigned held);
        int unsigned i;
        emit_char(hdrf_pkg::CH_SPACE, 1'b0);
        emit_char(hdrf_pkg::CH_BAR, 1'b0);
        for (i = 0; i < ROW_LEN; i++)
            emit_char(i < held ? ascii_cell(row_buf[i]) : hdrf_pkg::CH_SPACE, 1'b0);
        emit_char(hdrf_pkg::CH_BAR, 1'b1);
    endtask

    // Work out the characters one accepted beat produces and queue them.
    task automatic format_beat(input hdrf_pkg::t_in_beat b);
        int                  k;
        hdrf_pkg::t_out_beat ch;
        line_len = 0;
        if (b.cmd == hdrf_pkg::CMD_DATA) begin
            if (dump_fresh) begin
                row_addr   = base_addr;
                dump_fresh = 1'b0;
            end
            if (row_fill == 0) begin
                for (k = 7; k >= 0; k--)
                    emit_char(nibble_glyph(row_addr[k*4 +: 4]), 1'b0);
                emit_char(hdrf_pkg::CH_SPACE, 1'b0);
                emit_char(hdrf_pkg::CH_SPACE, 1'b0);
            end
            row_buf[row_fill] = b.data_byte;
            emit_char(nibble_glyph(b.data_byte[7:4]), 1'b0);
            emit_char(nibble_glyph(b.data_byte[3:0]), 1'b0);
            emit_char(hdrf_pkg::CH_SPACE, 1'b0);
            if (row_fill + 1 >= ROW_LEN) begin
                close_row(ROW_LEN);
                row_fill = 0;
                row_addr = row_addr + ROW_LEN;
            end else begin
                row_fill++;
            end
        end else begin
            if (row_fill != 0) begin
                // Pad each missing byte slot with three spaces.
                for (k = row_fill; k < ROW_LEN; k++) begin
                    emit_char(hdrf_pkg::CH_SPACE, 1'b0);
                    emit_char(hdrf_pkg::CH_SPACE, 1'b0);
                    emit_char(hdrf_pkg::CH_SPACE, 1'b0);
                end
                close_row(row_fill);
            end
            row_fill   = 0;
            row_addr   = base_addr;
            dump_fresh = 1'b1;
        end
        for (k = 0; k < line_len; k++) begin
            ch             = line_chars[k];
            ch.last_of_run = (k == line_len - 1);
            text_q.push_back(ch);
        end
    endtask

    task automatic check_char(input hdrf_pkg::t_out_beat got);
        hdrf_pkg::t_out_beat want;
        if (text_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("%0t: unexpected beat: char %h row_end %b last %b",
                         $time, got.text_char, got.row_end, got.last_of_run);
        end else begin
            want = text_q.pop_front();
            if (got.text_char !== want.text_char || got.row_end !== want.row_end ||
                got.last_of_run !== want.last_of_run) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: mismatch: char %h row_end %b last %b, want %h %b %b",
                             $time, got.text_char, got.row_end, got.last_of_run,
                             want.text_char, want.row_end, want.last_of_run);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_fill   = 0;
            row_addr   = '0;
            base_addr  = '0;
            dump_fresh = 1'b1;
            text_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                base_addr = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                format_beat(i_in_data);
            if (i_out_valid && !i_out_stall)
                check_char(i_out_data);
        end
        o_outstanding <= text_q.size();
        o_mismatches  <= mismatch_cnt;
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Testbench top for the hex dump row formatter: stimulus, idling, watchdog and verdict.
module testbench;

    localparam int unsigned ROW_LEN        = 16;
    localparam int          DRAIN_CYCLES   = 100;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          WATCHDOG_LIMIT = 4000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    hdrf_pkg::t_in_beat  i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    hdrf_pkg::t_out_beat o_out_data;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [31:0]         i_cfg_data;

    int mismatches;
    int outstanding;
    int quiet_cycles = 0;
    bit calm_mode    = 1'b0;
    bit hold_req     = 1'b0;

    hex_dump_row_formatter_top #(.ROW_BYTES(ROW_LEN)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    hdrf_dump_checker #(.ROW_LEN(ROW_LEN)) dump_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_data    (o_out_data),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            4, 5, 6: return 8'($urandom_range(32, 126));
            7: begin
                case ($urandom_range(0, 5))
                    0:       return 8'd0;
                    1:       return 8'd31;
                    2:       return 8'd32;
                    3:       return 8'd126;
                    4:       return 8'd127;
                    default: return 8'd255;
                endcase
            end
            8:       return 8'($urandom_range(0, 31));
            9:       return 8'($urandom_range(127, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_beat(input logic cmd, input logic [7:0] value);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= {cmd, value};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        gap = calm_mode ? 0 : gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_base(input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every expected character, then let a finish settle.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_beats(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 9)
                send_beat(hdrf_pkg::CMD_FINISH, 8'($urandom_range(0, 255)));
            else
                send_beat(hdrf_pkg::CMD_DATA, pick_byte());
        end
    endtask

    // Receiver: random stall stretches, plus one long hold-off on request.
    initial begin
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (calm_mode || $urandom_range(0, 2) != 0) begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b1;
                repeat (gap_len() + 1) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("** hex_dump_row_formatter_top: FAILED **");
        $finish;
    end

    initial begin
        int         k;
        int         p;
        logic [7:0] b;
        logic [31:0] base;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Start just below the top so the second row offset wraps to zero.
        write_base(32'hFFFF_FFF0);
        for (k = 0; k < 16; k++) begin
            case (k)
                0:       b = 8'h00;
                1:       b = 8'hFF;
                2:       b = 8'h1F;
                3:       b = 8'h20;
                4:       b = 8'h7E;
                5:       b = 8'h7F;
                6:       b = 8'h80;
                7:       b = 8'h41;
                8:       b = 8'h7A;
                9:       b = 8'h30;
                10:      b = 8'h39;
                11:      b = 8'hA5;
                12:      b = 8'h5A;
                13:      b = 8'h0F;
                14:      b = 8'hF0;
                default: b = 8'h7C;
            endcase
            send_beat(hdrf_pkg::CMD_DATA, b);
        end
        for (k = 0; k < 3; k++)
            send_beat(hdrf_pkg::CMD_DATA, pick_byte());
        settle();

        // New base in the middle of a dump applies only to the next dump.
        write_base(32'h0000_1230);
        send_beat(hdrf_pkg::CMD_DATA, 8'h2E);
        send_beat(hdrf_pkg::CMD_DATA, 8'h09);
        send_beat(hdrf_pkg::CMD_FINISH, 8'hFF);
        send_beat(hdrf_pkg::CMD_FINISH, 8'h00);
        send_beat(hdrf_pkg::CMD_DATA, 8'hC3);
        send_beat(hdrf_pkg::CMD_FINISH, 8'h55);
        settle();

        for (p = 0; p < 6; p++) begin
            case (p)
                0:       base = 32'h0000_0000;
                1:       base = 32'hFFFF_FFFF;
                3:       base = 32'h8000_0000;
                default: base = $urandom;
            endcase
            write_base(base);
            calm_mode = (p == 2);
            hold_req  = (p == 4);
            random_beats(p == 4 ? 18 : 13);
            settle();
            calm_mode = 1'b0;
        end

        if (mismatches == 0 && outstanding == 0)
            $display("** hex_dump_row_formatter_top: PASSED **");
        else
            $display("** hex_dump_row_formatter_top: FAILED **");
        $finish;
    end

endmodule
